@@ rtl/rqdps_pkg.sv @@
`default_nettype none

package rqdps_pkg;

  // Store geometry
  localparam int unsigned CAPACITY  = 256;
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned MAX_BATCH = 16;

  // Field widths
  localparam int unsigned PTR_W    = 32;
  localparam int unsigned CNT_W    = 9;   // item counts, depth, peak
  localparam int unsigned LIMIT_W  = 5;   // batch limit field
  localparam int unsigned KIDX_W   = $clog2(MAX_BATCH + 1);
  localparam int unsigned OP_W     = 3;

  // Packed beat widths
  localparam int unsigned S_TDATA_W = 112;  // 110 bits of fields, zero filled
  localparam int unsigned M_TDATA_W = 152;  // 146 bits of fields, zero filled

  // Half-range mark for the stop-due compare
  localparam logic [PTR_W-1:0] HALF_RANGE = 32'h8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 3'd0,
    OP_PEEK       = 3'd1,
    OP_POP        = 3'd2,
    OP_DISCARD    = 3'd3,
    OP_STOP_MARK  = 3'd4,
    OP_STOP_CHECK = 3'd5,
    OP_BATCH      = 3'd6,
    OP_CONSUME    = 3'd7
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef logic [ADDR_W-1:0] slot_t;
  typedef logic [DATA_W-1:0] word_t;

  // One result beat
  typedef struct packed {
    logic                ok;
    logic [DATA_W-1:0]   data;
    logic [CNT_W-1:0]    count;
    logic [PTR_W-1:0]    serial;
    logic [PTR_W-1:0]    drops;
    logic [CNT_W-1:0]    peak;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/ring_queue_with_drop_peak_stop_top.sv @@
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid_i/tready_o      tuser: operation; tdata: push word and arguments
// m_axis    out  m_axis_tvalid_o/tready_i      tuser: ok; tdata: result fields; tlast: end of run
//
// Push, pop, discard, stop mark, stop check and consume each give one result beat.
// Peek and batch read start a read of the slot store (synchronous read),
// then emit one beat per cycle while the output is not stalled.
// A result beat sits in an output register; a new beat is taken in the cycle it leaves.
// Output stalls hold the batch; the read port re-reads the same slot each cycle.
// Reset clears pointers, counters and control; slot contents are not cleared.
`default_nettype none

module ring_queue_with_drop_peak_stop_top
  import rqdps_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [63:0] item_data, [95:64] seen_serial, [100:96] batch_limit,
  // [109:101] consume_count, [111:110] zero
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // [2:0] operation
  input  wire logic [OP_W-1:0]      s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [63:0] item_data_out, [72:64] item_count, [104:73] serial_out,
  // [136:105] drop_total, [145:137] peak_depth, [151:146] zero
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o,
  // [0] ok
  output logic                      m_axis_tuser_o,
  output logic                      m_axis_tlast_o
);

  // Input field split
  op_e               op;
  word_t             in_data;
  logic [PTR_W-1:0]  in_seen;
  logic [LIMIT_W-1:0] in_limit;
  logic [CNT_W-1:0]  in_want;

  assign op       = op_e'(s_axis_tuser_i);
  assign in_data  = s_axis_tdata_i[63:0];
  assign in_seen  = s_axis_tdata_i[95:64];
  assign in_limit = s_axis_tdata_i[100:96];
  assign in_want  = s_axis_tdata_i[109:101];

  // State registers
  state_e            state_q, state_d;
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic [PTR_W-1:0]  drop_q, drop_d;
  logic [CNT_W-1:0]  peak_q, peak_d;
  logic [PTR_W-1:0]  stop_pos_q, stop_pos_d;
  logic [PTR_W-1:0]  serial_q, serial_d;
  logic [KIDX_W-1:0] k_q, k_d;
  logic [KIDX_W-1:0] cnt_q, cnt_d;
  logic              peek_q, peek_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  result_t           res;
  logic              ld;

  // Slot store
  word_t             mem [CAPACITY];
  word_t             rd_data_q;
  slot_t             rd_addr;
  logic              wr_en;
  logic              adv;

  // Combinational helpers
  logic [PTR_W-1:0]  depth_w;
  logic [CNT_W-1:0]  depth;
  logic              full;
  logic              accept;
  logic              out_free;
  logic [CNT_W-1:0]  want;
  logic [CNT_W-1:0]  contig;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  bcnt;
  logic [PTR_W-1:0]  distance;
  logic              due;
  logic              last_k;

  assign depth_w  = wp_q - rp_q;
  assign depth    = depth_w[CNT_W-1:0];
  assign full     = (depth == CNT_W'(CAPACITY));
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign last_k   = (k_q + KIDX_W'(1)) == cnt_q;

  // Batch size: occupancy, wrap point, limit, then an open stop mark
  always_comb begin
    contig   = CNT_W'(CAPACITY) - CNT_W'(rp_q[ADDR_W-1:0]);
    lim      = (CNT_W'(in_limit) > CNT_W'(MAX_BATCH)) ? CNT_W'(MAX_BATCH)
                                                      : CNT_W'(in_limit);
    distance = stop_pos_q - rp_q;
    bcnt     = depth;
    if (bcnt > contig) begin
      bcnt = contig;
    end
    if (bcnt > lim) begin
      bcnt = lim;
    end
    if ((serial_q != in_seen) && (distance < PTR_W'(bcnt))) begin
      bcnt = distance[CNT_W-1:0];
    end
  end

  assign due  = (serial_q != in_seen) && ((rp_q - stop_pos_q) < HALF_RANGE);
  assign want = (in_want > depth) ? depth : in_want;

  // Operation decode and batch sequencing
  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    rp_d       = rp_q;
    drop_d     = drop_q;
    peak_d     = peak_q;
    stop_pos_d = stop_pos_q;
    serial_d   = serial_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    peek_d     = peek_q;
    wr_en      = 1'b0;
    adv        = 1'b0;
    ld         = 1'b0;
    res.ok     = 1'b0;
    res.data   = '0;
    res.count  = '0;
    res.last   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_PUSH: begin
              ld = 1'b1;
              if (full) begin
                drop_d = drop_q + PTR_W'(1);
              end else begin
                wr_en  = 1'b1;
                wp_d   = wp_q + PTR_W'(1);
                res.ok = 1'b1;
                if ((depth + CNT_W'(1)) > peak_q) begin
                  peak_d = depth + CNT_W'(1);
                end
              end
            end
            OP_PEEK: begin
              if (depth == '0) begin
                ld = 1'b1;
              end else begin
                state_d = ST_EMIT;
                cnt_d   = KIDX_W'(1);
                peek_d  = 1'b1;
              end
            end
            OP_POP: begin
              ld = 1'b1;
              if (depth != '0) begin
                rp_d   = rp_q + PTR_W'(1);
                res.ok = 1'b1;
              end
            end
            OP_DISCARD: begin
              ld        = 1'b1;
              rp_d      = wp_q;
              res.count = depth;
            end
            OP_STOP_MARK: begin
              ld         = 1'b1;
              stop_pos_d = wp_q;
              serial_d   = serial_q + PTR_W'(1);
            end
            OP_STOP_CHECK: begin
              ld     = 1'b1;
              res.ok = due;
            end
            OP_BATCH: begin
              if (bcnt == '0) begin
                ld = 1'b1;
              end else begin
                state_d = ST_EMIT;
                cnt_d   = bcnt[KIDX_W-1:0];
                peek_d  = 1'b0;
              end
            end
            OP_CONSUME: begin
              ld        = 1'b1;
              rp_d      = rp_q + PTR_W'(want);
              res.count = want;
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ld        = 1'b1;
          adv       = 1'b1;
          res.ok    = 1'b1;
          res.data  = rd_data_q;
          res.count = peek_q ? '0 : CNT_W'(cnt_q);
          res.last  = last_k;
          if (last_k) begin
            state_d = ST_IDLE;
            k_d     = '0;
          end else begin
            k_d = k_q + KIDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res.serial = serial_d;
    res.drops  = drop_d;
    res.peak   = peak_d;
  end

  // Read address runs one slot ahead once a beat leaves
  assign rd_addr = rp_q[ADDR_W-1:0] + slot_t'(k_q) + slot_t'(adv);

  always_comb begin
    if (ld) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      drop_q      <= '0;
      peak_q      <= '0;
      stop_pos_q  <= '0;
      serial_q    <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      peek_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      drop_q      <= drop_d;
      peak_q      <= peak_d;
      stop_pos_q  <= stop_pos_d;
      serial_q    <= serial_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      peek_q      <= peek_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_q <= res;
    end
  end

  // Slot store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q[ADDR_W-1:0]] <= in_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.ok;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {6'b0, out_q.peak, out_q.drops, out_q.serial,
                            out_q.count, out_q.data};

  // Occupancy never exceeds the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q - rp_q) <= PTR_W'(CAPACITY))
    else $error("occupancy above capacity");

  // Beat index stays inside the granted batch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (k_q < cnt_q))
    else $error("batch index out of range");

  // Pointers hold while a batch is emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |=> ($stable(wp_q) && $stable(rp_q)))
    else $error("pointer moved during batch");

  // An accepted push into a non-full queue advances the write pointer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_PUSH) && !full) |=> (wp_q == $past(wp_q) + PTR_W'(1)))
    else $error("push did not advance write pointer");

endmodule

`default_nettype wire

@@ tb/rqdps_checker.sv @@
`timescale 1ns / 100ps

// Watches both stream channels, predicts the ring queue behavior and
// compares every result beat against the oldest predicted beat.
module rqdps_checker
  import rqdps_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_tvalid_i,
  input  wire logic                 s_tready_i,
  input  wire logic [S_TDATA_W-1:0] s_tdata_i,
  input  wire logic [OP_W-1:0]      s_tuser_i,
  input  wire logic                 m_tvalid_i,
  input  wire logic                 m_tready_i,
  input  wire logic [M_TDATA_W-1:0] m_tdata_i,
  input  wire logic                 m_tuser_i,
  input  wire logic                 m_tlast_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        beats_o,
  output logic [PTR_W-1:0]          drops_o,
  output logic [CNT_W-1:0]          peak_o
);

  // Predicted queue state
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] drop_cnt;
  logic [CNT_W-1:0] peak_occ;
  logic [PTR_W-1:0] stop_pos;
  logic [PTR_W-1:0] stop_num;
  word_t            slots [CAPACITY];

  result_t expected_beats [$];
  int fails = 0;
  int beats = 0;

  // Queue one predicted beat, status fields taken from the state after the op
  task automatic add_beat(logic ok, word_t d, logic [CNT_W-1:0] cnt, logic lst);
    result_t r;
    r.ok     = ok;
    r.data   = d;
    r.count  = cnt;
    r.serial = stop_num;
    r.drops  = drop_cnt;
    r.peak   = peak_occ;
    r.last   = lst;
    expected_beats.push_back(r);
  endtask

  // Apply one accepted operation to the predicted state
  task automatic apply_op(op_e op, word_t d, logic [PTR_W-1:0] seen,
                          logic [LIMIT_W-1:0] lim_in, logic [CNT_W-1:0] want_in);
    logic [PTR_W-1:0] depth;
    logic [PTR_W-1:0] grant;
    logic [PTR_W-1:0] contig;
    logic [PTR_W-1:0] stop_gap;
    logic [PTR_W-1:0] lim;
    logic [PTR_W-1:0] want;
    logic [PTR_W-1:0] addr;
    logic             due;
    depth = wr_ptr - rd_ptr;
    case (op)
      OP_PUSH: begin
        if (depth >= CAPACITY) begin
          drop_cnt = drop_cnt + 1;
          add_beat(1'b0, '0, '0, 1'b1);
        end else begin
          slots[wr_ptr[ADDR_W-1:0]] = d;
          wr_ptr = wr_ptr + 1;
          if (depth + 1 > peak_occ) peak_occ = CNT_W'(depth + 1);
          add_beat(1'b1, '0, '0, 1'b1);
        end
      end
      OP_PEEK: begin
        if (depth == 0) add_beat(1'b0, '0, '0, 1'b1);
        else add_beat(1'b1, slots[rd_ptr[ADDR_W-1:0]], '0, 1'b1);
      end
      OP_POP: begin
        if (depth == 0) begin
          add_beat(1'b0, '0, '0, 1'b1);
        end else begin
          rd_ptr = rd_ptr + 1;
          add_beat(1'b1, '0, '0, 1'b1);
        end
      end
      OP_DISCARD: begin
        rd_ptr = wr_ptr;
        add_beat(1'b0, '0, CNT_W'(depth), 1'b1);
      end
      OP_STOP_MARK: begin
        stop_pos = wr_ptr;
        stop_num = stop_num + 1;
        add_beat(1'b0, '0, '0, 1'b1);
      end
      OP_STOP_CHECK: begin
        due = (stop_num != seen) && ((rd_ptr - stop_pos) < HALF_RANGE);
        add_beat(due, '0, '0, 1'b1);
      end
      OP_BATCH: begin
        grant  = depth;
        contig = CAPACITY - PTR_W'(rd_ptr[ADDR_W-1:0]);
        lim    = PTR_W'(lim_in);
        if (lim > MAX_BATCH) lim = MAX_BATCH;
        if (grant > contig) grant = contig;
        if (grant > lim) grant = lim;
        // an unacknowledged stop bounds the batch; a mark behind us wraps
        if (stop_num != seen) begin
          stop_gap = stop_pos - rd_ptr;
          if (stop_gap < grant) grant = stop_gap;
        end
        if (grant == 0) begin
          add_beat(1'b0, '0, '0, 1'b1);
        end else begin
          for (int k = 0; k < grant; k++) begin
            addr = rd_ptr + PTR_W'(k);
            add_beat(1'b1, slots[addr[ADDR_W-1:0]], CNT_W'(grant), (k + 1) == grant);
          end
        end
      end
      default: begin
        // consume, clamped to occupancy
        want = PTR_W'(want_in);
        if (want > depth) want = depth;
        rd_ptr = rd_ptr + want;
        add_beat(1'b0, '0, CNT_W'(want), 1'b1);
      end
    endcase
  endtask

  // Compare one accepted result beat with the oldest prediction
  task automatic check_beat();
    result_t got;
    result_t ref_beat;
    got.ok     = m_tuser_i;
    got.data   = m_tdata_i[63:0];
    got.count  = m_tdata_i[72:64];
    got.serial = m_tdata_i[104:73];
    got.drops  = m_tdata_i[136:105];
    got.peak   = m_tdata_i[145:137];
    got.last   = m_tlast_i;
    beats++;
    if (expected_beats.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("beat %0d: unexpected result ok=%0d data=%h cnt=%0d", beats,
                 got.ok, got.data, got.count);
    end else begin
      ref_beat = expected_beats.pop_front();
      if (got.ok !== ref_beat.ok || got.data !== ref_beat.data ||
          got.count !== ref_beat.count || got.serial !== ref_beat.serial ||
          got.drops !== ref_beat.drops || got.peak !== ref_beat.peak ||
          got.last !== ref_beat.last) begin
        fails++;
        if (fails <= 10) begin
          $display("beat %0d mismatch, exp: ok=%0d data=%h cnt=%0d ser=%h drop=%0d pk=%0d last=%0d",
                   beats, ref_beat.ok, ref_beat.data, ref_beat.count, ref_beat.serial,
                   ref_beat.drops, ref_beat.peak, ref_beat.last);
          $display("          got: ok=%0d data=%h cnt=%0d ser=%h drop=%0d pk=%0d last=%0d",
                   got.ok, got.data, got.count, got.serial, got.drops, got.peak, got.last);
        end
      end
    end
  endtask

  // Values sampled at the edge are the pre-edge values of both channels
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      wr_ptr   = '0;
      rd_ptr   = '0;
      drop_cnt = '0;
      peak_occ = '0;
      stop_pos = '0;
      stop_num = '0;
      expected_beats.delete();
    end else begin
      if (s_tvalid_i && s_tready_i)
        apply_op(op_e'(s_tuser_i), s_tdata_i[63:0], s_tdata_i[95:64],
                 s_tdata_i[100:96], s_tdata_i[109:101]);
      if (m_tvalid_i && m_tready_i) check_beat();
    end
    fail_count_o <= fails;
    pending_o    <= expected_beats.size();
    beats_o      <= beats;
    drops_o      <= drop_cnt;
    peak_o       <= peak_occ;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import rqdps_pkg::*;

  localparam int RAND_ITEMS  = 370;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk_i;
  logic                 rst_n      = 1'b0;
  logic                 s_tvalid   = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata    = '0;
  logic [OP_W-1:0]      s_tuser    = '0;
  logic                 m_tvalid;
  logic                 m_tready   = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;

  int               fail_count;
  int               pending;
  int               beats;
  logic [PTR_W-1:0] drops;
  logic [CNT_W-1:0] peak;

  int               cycles     = 0;
  int               burst_left = 0;
  int               op_sent [8];
  logic [PTR_W-1:0] mark_count = '0;

  ring_queue_with_drop_peak_stop_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  rqdps_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .beats_o      (beats),
    .drops_o      (drops),
    .peak_o       (peak)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Cycle count and watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver stall pattern: always ready, coin flip, 3 of 5, mostly stalled
  always @(posedge clk_i) begin
    case (cycles[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (cycles % 5) < 3;
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // One input beat; bursts of random length with random gaps between them
  task automatic send_item(op_e op, logic [63:0] d, logic [31:0] seen,
                           logic [4:0] lim, logic [8:0] want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, want, lim, seen, d};
    do @(posedge clk_i); while (!s_tready);
    op_sent[op]++;
    if (op == OP_STOP_MARK) mark_count++;
  endtask

  // Mostly the current or previous serial, so stops actually bound batches
  function automatic logic [31:0] pick_seen();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return mark_count;
    if (r < 7) return mark_count - 1;
    return $urandom;
  endfunction

  function automatic logic [63:0] pick_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  // Phase 0 mixed, phase 1 fills the queue past full, phase 2 drains it
  function automatic op_e pick_op(int phase);
    int r;
    r = $urandom_range(0, 15);
    case (phase)
      0: begin
        if (r < 6) return OP_PUSH;
        return op_e'(1 + (r % 7));
      end
      1: begin
        if (r < 15) return OP_PUSH;
        case ($urandom_range(0, 3))
          0: return OP_PEEK;
          1: return OP_STOP_MARK;
          2: return OP_STOP_CHECK;
          default: return OP_BATCH;
        endcase
      end
      default: begin
        if (r < 3) return OP_PUSH;
        if (r < 6 || r > 13) return OP_BATCH;
        if (r < 9) return OP_CONSUME;
        case (r)
          9: return OP_POP;
          10: return OP_PEEK;
          11: return OP_STOP_CHECK;
          12: return OP_STOP_MARK;
          default: return OP_DISCARD;
        endcase
      end
    endcase
  endfunction

  initial begin
    int phase;
    foreach (op_sent[i]) op_sent[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-queue corners
    send_item(OP_PEEK, '0, 32'd0, 5'd16, 9'd0);
    send_item(OP_POP, '0, 32'd0, 5'd16, 9'd0);
    send_item(OP_BATCH, '0, 32'd0, 5'd16, 9'd0);
    send_item(OP_STOP_CHECK, '0, 32'd0, 5'd0, 9'd0);
    send_item(OP_CONSUME, '0, 32'd0, 5'd0, 9'd511);
    send_item(OP_DISCARD, '0, 32'd0, 5'd0, 9'd0);
    // data extremes, peek
    send_item(OP_PUSH, 64'h0, 32'd0, 5'd0, 9'd0);
    send_item(OP_PUSH, '1, 32'hFFFF_FFFF, 5'd31, 9'd511);
    send_item(OP_PUSH, 64'hA5A5_5A5A_C3C3_3C3C, 32'd0, 5'd0, 9'd0);
    send_item(OP_PEEK, '0, 32'd0, 5'd0, 9'd0);
    // stop mark ahead of the reader bounds a batch
    send_item(OP_STOP_MARK, '0, 32'd0, 5'd0, 9'd0);
    send_item(OP_PUSH, 64'h0123_4567_89AB_CDEF, 32'd0, 5'd0, 9'd0);
    send_item(OP_STOP_CHECK, '0, 32'd0, 5'd0, 9'd0);
    send_item(OP_BATCH, '0, 32'd0, 5'd31, 9'd0);
    send_item(OP_BATCH, '0, 32'd1, 5'd31, 9'd0);
    send_item(OP_BATCH, '0, 32'd1, 5'd0, 9'd0);
    send_item(OP_CONSUME, '0, 32'd0, 5'd0, 9'd3);
    // stop due once reached, not due when already acknowledged
    send_item(OP_STOP_CHECK, '0, 32'd0, 5'd0, 9'd0);
    send_item(OP_STOP_CHECK, '0, 32'd1, 5'd0, 9'd0);
    send_item(OP_POP, '0, 32'd0, 5'd0, 9'd0);
    send_item(OP_POP, '0, 32'd0, 5'd0, 9'd0);
    // stop mark left behind the reader does not limit a batch
    send_item(OP_STOP_MARK, '0, 32'd0, 5'd0, 9'd0);
    send_item(OP_PUSH, 64'hFFFF_0000_FFFF_0000, 32'd0, 5'd0, 9'd0);
    send_item(OP_PUSH, 64'h0000_FFFF_0000_FFFF, 32'd0, 5'd0, 9'd0);
    send_item(OP_CONSUME, '0, 32'd0, 5'd0, 9'd1);
    send_item(OP_BATCH, '0, 32'd1, 5'd16, 9'd0);
    send_item(OP_DISCARD, '0, 32'd0, 5'd0, 9'd0);

    // Random part
    for (int i = 0; i < RAND_ITEMS; i++) begin
      phase = (i < 40) ? 0 : (i < 320) ? 1 : 2;
      send_item(pick_op(phase), pick_word(), pick_seen(),
                ($urandom_range(0, 1) != 0) ? 5'($urandom_range(1, 16))
                                            : 5'($urandom_range(0, 31)),
                ($urandom_range(0, 9) < 7) ? 9'($urandom_range(0, 20))
                                           : 9'($urandom_range(0, 511)));
    end
    s_tvalid <= 1'b0;

    // Drain outstanding beats, then let the output settle
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d pushes, %0d peeks, %0d pops, %0d discards, %0d marks, %0d checks,",
             op_sent[OP_PUSH], op_sent[OP_PEEK], op_sent[OP_POP], op_sent[OP_DISCARD],
             op_sent[OP_STOP_MARK], op_sent[OP_STOP_CHECK]);
    $display("  %0d batch reads, %0d consumes; %0d beats checked, peak depth %0d, %0d drops",
             op_sent[OP_BATCH], op_sent[OP_CONSUME], beats, peak, drops);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
